// ===== src/dbkem_pkg.sv =====
// ----------------------------------------------------------------------------
// dbkem_pkg
// Shared types and constants for the debounced button key event mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package dbkem_pkg;

  localparam int NUM_BUTTONS = 7;
  localparam int NUM_SLOTS   = 11;

  // button bit positions
  localparam int BIT_CENTER = 4;
  localparam int BIT_A      = 5;
  localparam int BIT_B      = 6;

  // key codes
  localparam logic [3:0] KC_UP    = 4'd0;
  localparam logic [3:0] KC_DOWN  = 4'd1;
  localparam logic [3:0] KC_LEFT  = 4'd2;
  localparam logic [3:0] KC_RIGHT = 4'd3;
  localparam logic [3:0] KC_USE   = 4'd4;
  localparam logic [3:0] KC_ENTER = 4'd5;
  localparam logic [3:0] KC_NEXTW = 4'd6;
  localparam logic [3:0] KC_FIRE  = 4'd7;
  localparam logic [3:0] KC_BACK  = 4'd8;

  // configuration register indexes
  localparam logic REG_DEBOUNCE = 1'b0;
  localparam logic REG_HOLD     = 1'b1;

  typedef struct packed {
    logic [3:0] code;
    logic       down;
  } key_event_t;

  // fixed event slots of one tick, lowest set bit goes out first
  typedef struct packed {
    logic [NUM_SLOTS-1:0]       mask;
    key_event_t [NUM_SLOTS-1:0] ev;
  } event_list_t;

  // latched button state before and after the debounce update
  typedef struct packed {
    logic [NUM_BUTTONS-1:0] prev;
    logic [NUM_BUTTONS-1:0] cur;
  } latch_state_t;

endpackage

`default_nettype wire

// ===== src/debounced_button_key_event_mapper_core.sv =====
// ----------------------------------------------------------------------------
// debounced_button_key_event_mapper_core
// Debounces seven buttons per poll word and sends key down/up event words.
//
// Input channel: one word per poll tick (in_buttons_low active low,
// in_menu_open), taken when in_valid is high and in_stall low.
// Output channel: one event word per cycle while out_stall is low
// (out_key_code, out_key_down, out_last), out_last marks the final event
// of a tick; a tick with an empty event list produces nothing.
// Seven debounce lanes update at the edge a word is taken, where the event
// list is stored in the buffer; it moves on to the output register once
// that register is free, and its first event word is then offered.
// Events then leave at one per cycle while out_stall is low. One further
// tick is buffered while the current list drains and can be taken in the
// cycle the buffer empties, so a new tick can be taken before the previous
// one has left the single output port. Ticks with no events do not occupy
// the buffer.
// When out_stall is high the current event word holds; once the buffer is
// also full in_stall goes high. Reset clears counters, latched buttons,
// the use hold counter and both buffers and loads the register defaults
// (debounce 2 ticks, center hold 4 ticks). The APB port is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module debounced_button_key_event_mapper_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [6:0]  in_buttons_low,
  input  wire logic        in_menu_open,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       out_key_code,
  output logic             out_key_down,
  output logic             out_last,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  import dbkem_pkg::*;

  logic [3:0]   settle_polls_r;
  logic [3:0]   center_hold_r;
  logic         cfg_wr;
  logic         in_accept;
  logic         busy;
  latch_state_t latch;
  event_list_t  list;

  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite;
  assign in_accept = in_valid && !busy;
  assign in_stall  = busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_polls_r <= 4'd2;
      center_hold_r  <= 4'd4;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_DEBOUNCE: settle_polls_r <= pwdata[3:0];
        REG_HOLD:     center_hold_r  <= pwdata[3:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_DEBOUNCE: prdata = {28'd0, settle_polls_r};
      REG_HOLD:     prdata = {28'd0, center_hold_r};
      default:      prdata = '0;
    endcase
  end

  for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
    dbkem_lane u_lane (
      .clk          (clk),
      .rst_n        (rst_n),
      .accept       (in_accept),
      .pressed      (~in_buttons_low[i]),
      .settle_polls (settle_polls_r),
      .latched      (latch.prev[i]),
      .latched_nxt  (latch.cur[i])
    );
  end

  dbkem_merge u_merge (
    .clk               (clk),
    .rst_n             (rst_n),
    .accept            (in_accept),
    .latch             (latch),
    .menu_open         (in_menu_open),
    .center_hold_ticks (center_hold_r),
    .list              (list)
  );

  dbkem_serial u_serial (
    .clk          (clk),
    .rst_n        (rst_n),
    .load         (in_accept),
    .list         (list),
    .busy         (busy),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_key_code (out_key_code),
    .out_key_down (out_key_down),
    .out_last     (out_last)
  );

endmodule

`default_nettype wire

// ===== src/dbkem_lane.sv =====
// ----------------------------------------------------------------------------
// dbkem_lane
// Debounce counter and latched state for one button.
// ----------------------------------------------------------------------------
`default_nettype none

module dbkem_lane (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       accept,
  input  wire logic       pressed,
  input  wire logic [3:0] settle_polls,
  output logic            latched,
  output logic            latched_nxt
);

  logic [3:0] count_r;
  logic [3:0] count_nxt;
  logic       latched_r;
  logic [3:0] inc;
  logic       differ;
  logic       flip;

  always_comb begin
    differ      = (pressed != latched_r);
    inc         = count_r + 4'd1;
    flip        = differ && (inc >= settle_polls);
    count_nxt   = (differ && !flip) ? inc : 4'd0;
    latched_nxt = latched_r ^ flip;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= 4'd0;
      latched_r <= 1'b0;
    end else if (accept) begin
      count_r   <= count_nxt;
      latched_r <= latched_nxt;
    end
  end

  assign latched = latched_r;

endmodule

`default_nettype wire

// ===== src/dbkem_merge.sv =====
// ----------------------------------------------------------------------------
// dbkem_merge
// Turns the lanes' latched edges and the center use hold into the ordered event slots of one tick.
// ----------------------------------------------------------------------------
`default_nettype none

module dbkem_merge (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   accept,
  input  wire dbkem_pkg::latch_state_t latch,
  input  wire logic                   menu_open,
  input  wire logic [3:0]             center_hold_ticks,
  output dbkem_pkg::event_list_t      list
);

  import dbkem_pkg::*;

  logic [3:0]             hold_r;
  logic [3:0]             hold_nxt;
  logic [3:0]             hold_a;
  logic [NUM_BUTTONS-1:0] pe;
  logic [NUM_BUTTONS-1:0] re;
  logic                   deferred_up;

  always_comb begin
    pe = latch.cur & ~latch.prev;
    re = ~latch.cur & latch.prev;

    hold_a      = pe[BIT_CENTER] ? center_hold_ticks : hold_r;
    hold_nxt    = hold_a - {3'd0, (hold_a != 4'd0)};
    deferred_up = (hold_a == 4'd1) && !latch.cur[BIT_CENTER];

    for (int i = 0; i < 4; i++) begin
      list.mask[i]    = pe[i] | re[i];
      list.ev[i].code = 4'(i);
      list.ev[i].down = pe[i];
    end

    // center: use then enter
    list.mask[4]    = pe[BIT_CENTER] | (re[BIT_CENTER] && (hold_r == 4'd0));
    list.ev[4].code = KC_USE;
    list.ev[4].down = pe[BIT_CENTER];
    list.mask[5]    = (pe[BIT_CENTER] & menu_open) | re[BIT_CENTER];
    list.ev[5].code = KC_ENTER;
    list.ev[5].down = pe[BIT_CENTER];

    // a: press maps by menu, release sends both keyups
    list.mask[6]    = pe[BIT_A] | re[BIT_A];
    list.ev[6].code = (pe[BIT_A] && !menu_open) ? KC_NEXTW : KC_ENTER;
    list.ev[6].down = pe[BIT_A];
    list.mask[7]    = re[BIT_A];
    list.ev[7].code = KC_NEXTW;
    list.ev[7].down = 1'b0;

    list.mask[8]    = pe[BIT_B] | re[BIT_B];
    list.ev[8].code = (pe[BIT_B] && !menu_open) ? KC_FIRE : KC_BACK;
    list.ev[8].down = pe[BIT_B];
    list.mask[9]    = re[BIT_B];
    list.ev[9].code = KC_FIRE;
    list.ev[9].down = 1'b0;

    list.mask[10]    = deferred_up;
    list.ev[10].code = KC_USE;
    list.ev[10].down = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 4'd0;
    end else if (accept) begin
      hold_r <= hold_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/dbkem_serial.sv =====
// ----------------------------------------------------------------------------
// dbkem_serial
// Two-deep event list buffer that sends one event word per cycle while out_stall is low.
// ----------------------------------------------------------------------------
`default_nettype none

module dbkem_serial (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   load,
  input  wire dbkem_pkg::event_list_t list,
  output logic                        busy,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [3:0]                  out_key_code,
  output logic                        out_key_down,
  output logic                        out_last
);

  import dbkem_pkg::*;

  logic                       pend_valid_r;
  logic                       pend_valid_nxt;
  event_list_t                pend_r;
  logic [NUM_SLOTS-1:0]       act_mask_r;
  logic [NUM_SLOTS-1:0]       act_mask_nxt;
  key_event_t [NUM_SLOTS-1:0] act_ev_r;
  logic [NUM_SLOTS-1:0]       first;
  logic [NUM_SLOTS-1:0]       rest;
  logic                       pop;
  logic                       act_free;
  logic                       move;
  key_event_t                 sel;

  always_comb begin
    // isolate lowest pending slot
    first = act_mask_r & (~act_mask_r + 1'b1);
    rest  = act_mask_r & ~first;
    sel   = '0;
    for (int k = 0; k < NUM_SLOTS; k++) begin
      if (first[k]) begin
        sel = sel | act_ev_r[k];
      end
    end
    out_valid = |act_mask_r;
    pop       = out_valid && !out_stall;
    act_free  = !out_valid || (pop && (rest == '0));
    move      = act_free && pend_valid_r;

    act_mask_nxt = act_mask_r;
    if (pop) begin
      act_mask_nxt = rest;
    end
    if (move) begin
      act_mask_nxt = pend_r.mask;
    end

    pend_valid_nxt = pend_valid_r;
    if (move) begin
      pend_valid_nxt = 1'b0;
    end
    if (load && (list.mask != '0)) begin
      pend_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      act_mask_r   <= '0;
    end else begin
      pend_valid_r <= pend_valid_nxt;
      act_mask_r   <= act_mask_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pend_r <= list;
    end
    if (move) begin
      act_ev_r <= pend_r.ev;
    end
  end

  // the buffer frees up in the cycle its list moves on
  assign busy         = pend_valid_r && !move;
  assign out_key_code = sel.code;
  assign out_key_down = sel.down;
  assign out_last     = (rest == '0);

endmodule

`default_nettype wire

// ===== src/dbkem_checker.sv =====
// ----------------------------------------------------------------------------
// dbkem_checker
// Port-level checks for the key event mapper, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dbkem_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [3:0] out_key_code,
  input wire logic       out_key_down,
  input wire logic       out_last
);

  import dbkem_pkg::*;

  // reset empties the event buffers
  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("event word valid right after reset");

  a_reset_in: assert property (@(posedge clk) !rst_n |=> !in_stall)
    else $error("input stalled right after reset");

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_key_code <= KC_BACK))
    else $error("key code out of range");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_key_code)
      && $stable(out_key_down) && $stable(out_last))
    else $error("stalled event word changed");

endmodule

bind debounced_button_key_event_mapper_core dbkem_checker u_dbkem_checker (.*);

`default_nettype wire

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for debounced_button_key_event_mapper_core. Poll words
// go in on the valid/stall channel with random gaps. Key event words are
// drained under random back-pressure and checked in order against a model
// of the debounce lanes, the edge detection and the key mapping. The two
// registers are set over the APB port to several values, the extremes
// among them, and read back after each write.
// ----------------------------------------------------------------------------
module tb_top;
  import dbkem_pkg::*;

  localparam int CYCLE_LIMIT    = 400000;
  localparam int IDLE_PCT       = 17;
  localparam int SETTLE_CYCLES  = 8;
  localparam logic [3:0] DEBOUNCE_RESET = 4'd2;
  localparam logic [3:0] HOLD_RESET     = 4'd4;
  localparam logic [6:0] ALL_RELEASED   = 7'h7f;
  localparam logic [6:0] ALL_PRESSED    = 7'h00;

  typedef struct packed {
    logic [3:0] code;
    logic       down;
    logic       last;
  } key_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [6:0]  in_buttons_low = ALL_RELEASED;
  logic        in_menu_open = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  out_key_code;
  logic        out_key_down;
  logic        out_last;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  bit idling_on = 1'b1;
  int mismatch_count = 0;
  int cycle_count = 0;

  // predicted block state and register copies
  logic [3:0] settle_polls;
  logic [3:0] hold_ticks;
  logic [3:0] lane_count [NUM_BUTTONS];
  logic [6:0] latched;
  logic [3:0] hold_left;
  key_word_t  pending_keys[$];

  debounced_button_key_event_mapper_core uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_buttons_low(in_buttons_low),
    .in_menu_open(in_menu_open),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_key_code(out_key_code),
    .out_key_down(out_key_down),
    .out_last(out_last),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d key words outstanding", cycle_count,
               pending_keys.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= idling_on && ($urandom_range(99) < IDLE_PCT);
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : check_word
    key_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_keys.size() == 0) begin
        report_mismatch($sformatf("unexpected word code=%0d down=%0b last=%0b",
                                  out_key_code, out_key_down, out_last));
      end else begin
        want = pending_keys.pop_front();
        if (out_key_code !== want.code)
          report_mismatch($sformatf("key_code %0d, want %0d", out_key_code, want.code));
        if (out_key_down !== want.down)
          report_mismatch($sformatf("key_down %0b, want %0b (code %0d)", out_key_down,
                                    want.down, want.code));
        if (out_last !== want.last)
          report_mismatch($sformatf("last %0b, want %0b (code %0d)", out_last, want.last,
                                    want.code));
      end
    end
  end

  function automatic void add_key(input logic [3:0] code, input logic down);
    key_word_t w;
    w.code = code;
    w.down = down;
    w.last = 1'b0;
    pending_keys.push_back(w);
  endfunction

  function automatic void predict_keys(input logic [6:0] btn_low, input logic menu);
    logic [6:0] raw;
    logic [6:0] prev;
    logic [6:0] pe;
    logic [6:0] re;
    int         old_size;
    key_word_t  w;
    raw = ~btn_low;
    prev = latched;
    old_size = pending_keys.size();
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      if (raw[i] != latched[i]) begin
        lane_count[i] = lane_count[i] + 4'd1;
        if (lane_count[i] >= settle_polls) begin
          latched[i] = ~latched[i];
          lane_count[i] = 4'd0;
        end
      end else begin
        lane_count[i] = 4'd0;
      end
    end
    pe = latched & ~prev;
    re = ~latched & prev;
    for (int i = 0; i < 4; i++) begin
      if (pe[i]) add_key(KC_UP + 4'(i), 1'b1);
      if (re[i]) add_key(KC_UP + 4'(i), 1'b0);
    end
    if (pe[BIT_CENTER]) begin
      add_key(KC_USE, 1'b1);
      hold_left = hold_ticks;
      if (menu) add_key(KC_ENTER, 1'b1);
    end else if (re[BIT_CENTER]) begin
      // use up waits for the hold to run out
      if (hold_left == 4'd0) add_key(KC_USE, 1'b0);
      add_key(KC_ENTER, 1'b0);
    end
    if (pe[BIT_A]) add_key(menu ? KC_ENTER : KC_NEXTW, 1'b1);
    if (re[BIT_A]) begin
      add_key(KC_ENTER, 1'b0);
      add_key(KC_NEXTW, 1'b0);
    end
    if (pe[BIT_B]) add_key(menu ? KC_BACK : KC_FIRE, 1'b1);
    if (re[BIT_B]) begin
      add_key(KC_BACK, 1'b0);
      add_key(KC_FIRE, 1'b0);
    end
    if (hold_left != 4'd0) begin
      hold_left = hold_left - 4'd1;
      if (hold_left == 4'd0 && !latched[BIT_CENTER]) add_key(KC_USE, 1'b0);
    end
    if (pending_keys.size() > old_size) begin
      w = pending_keys.pop_back();
      w.last = 1'b1;
      pending_keys.push_back(w);
    end
  endfunction

  task automatic send_tick(input logic [6:0] btn_low, input logic menu);
    while (idling_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_buttons_low <= btn_low;
    in_menu_open <= menu;
    do @(posedge clk); while (in_stall);
    predict_keys(btn_low, menu);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_keys.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic idx, input logic [3:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_DEBOUNCE) settle_polls = value;
    else hold_ticks = value;
    // read back right away
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[3:0] !== value)
      report_mismatch($sformatf("register %0d reads %0d, want %0d", idx, prdata[3:0], value));
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [3:0] deb, input logic [3:0] hold);
    wait_drained();
    cfg_write(REG_DEBOUNCE, deb);
    cfg_write(REG_HOLD, hold);
  endtask

  task automatic run_random(input int n_items);
    logic [6:0] pattern;
    logic       menu;
    int         sent;
    int         kind;
    int         run_len;
    sent = 0;
    pattern = ~latched;
    while (sent < n_items) begin
      kind = $urandom_range(99);
      if (kind < 80) begin
        // hold a level pattern, mostly long enough to get through the debounce
        if (kind < 40) pattern = pattern ^ (7'd1 << $urandom_range(6));
        else pattern = 7'($urandom);
        run_len = int'(settle_polls) + $urandom_range(2);
        if (kind % 8 == 0) run_len = $urandom_range(int'(settle_polls));
        if (run_len == 0) run_len = 1;
        menu = 1'($urandom);
        repeat (run_len) begin
          send_tick(pattern, menu ^ ($urandom_range(9) == 0));
          sent++;
        end
      end else begin
        send_tick(7'($urandom), 1'($urandom));
        sent++;
      end
    end
  endtask

  task automatic test_directed_defaults();
    send_tick(ALL_RELEASED, 1'b0);
    // short glitches on up never reach the latch
    send_tick(7'h7e, 1'b0);
    send_tick(ALL_RELEASED, 1'b0);
    send_tick(7'h7e, 1'b0);
    // everything pressed, then held past the use hold
    repeat (2) send_tick(ALL_PRESSED, 1'b0);
    repeat (3) send_tick(ALL_PRESSED, 1'b0);
    // release of all seven at once
    repeat (2) send_tick(ALL_RELEASED, 1'b1);
    repeat (2) send_tick(ALL_PRESSED, 1'b1);
    // center let go inside the hold, deferred use up follows
    repeat (3) send_tick(7'h10, 1'b1);
    repeat (2) send_tick(ALL_PRESSED, 1'b1);
    repeat (2) send_tick(7'h10, 1'b0);
    // center pressed again while the hold still runs
    repeat (2) send_tick(ALL_PRESSED, 1'b0);
  endtask

  task automatic test_zero_debounce();
    set_config(4'd0, 4'd0);
    send_tick(ALL_RELEASED, 1'b0);
    send_tick(7'h6f, 1'b1);
    send_tick(ALL_RELEASED, 1'b0);
  endtask

  task automatic test_random_fast();
    set_config(4'd1, 4'd0);
    run_random(45);
  endtask

  task automatic test_random_slow();
    set_config(4'd15, 4'd15);
    run_random(60);
  endtask

  task automatic test_random_steady();
    set_config(4'd0, 4'd9);
    idling_on = 1'b0;
    run_random(35);
    wait_drained();
    idling_on = 1'b1;
  endtask

  task automatic test_random_mixed();
    repeat (3) begin
      set_config(4'($urandom_range(15, 1)), 4'($urandom_range(15)));
      run_random(20);
    end
  endtask

  initial begin
    for (int i = 0; i < NUM_BUTTONS; i++) lane_count[i] = 4'd0;
    latched = '0;
    hold_left = 4'd0;
    settle_polls = DEBOUNCE_RESET;
    hold_ticks = HOLD_RESET;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_defaults();
    test_zero_debounce();
    test_random_fast();
    test_random_slow();
    test_random_steady();
    test_random_mixed();
    wait_drained();
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/dbkem_pkg.sv
src/dbkem_lane.sv
src/dbkem_merge.sv
src/dbkem_serial.sv
src/debounced_button_key_event_mapper_core.sv
src/dbkem_checker.sv
sim/tb_top.sv
